/* rtl/sta_pkg.sv */
// Shared constants, types and width helpers for the segment triangle area core.
package sta_pkg;

    localparam int IN_W           = 16;
    localparam int AREA_W         = 51;
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH    = 4;
    localparam int N_COORD        = 12;
    localparam int N_PAIR         = 3;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // unsigned width of the denominator and t numerator after sign fix
    function automatic int num_w(int cb);
        return 2 * cb + 2;
    endfunction

    // width of t numerator times |segment delta|
    function automatic int prod_w(int cb);
        return 3 * cb + 3;
    endfunction

    // width of the scaled step quotient
    function automatic int quo_w(int cb, int fb);
        return cb + fb + 1;
    endfunction

endpackage

/* rtl/sta_front.sv */
// Front pipeline: segment pair determinants, range tests and step dividends.
module sta_front #(
    parameter int COORD_BITS = sta_pkg::COORD_BITS_DEF
) (
    input  logic                                                      clk,
    input  logic                                                      rst_n,
    input  logic                                                      item_valid,
    output logic                                                      item_ready,
    input  logic [sta_pkg::N_COORD-1:0][sta_pkg::IN_W-1:0]            coord,
    input  sta_pkg::q_stat_t                                          q_stat,
    output logic                                                      push,
    output logic [sta_pkg::N_PAIR-1:0]                                hit,
    output logic [sta_pkg::N_PAIR-1:0]                                sx,
    output logic [sta_pkg::N_PAIR-1:0]                                sy,
    output logic [sta_pkg::N_PAIR-1:0][COORD_BITS-1:0]                x1,
    output logic [sta_pkg::N_PAIR-1:0][COORD_BITS-1:0]                y1,
    output logic [sta_pkg::N_PAIR-1:0][sta_pkg::num_w(COORD_BITS)-1:0]  d,
    output logic [sta_pkg::N_PAIR-1:0][sta_pkg::prod_w(COORD_BITS)-1:0] mx,
    output logic [sta_pkg::N_PAIR-1:0][sta_pkg::prod_w(COORD_BITS)-1:0] my
);
    import sta_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;
    localparam int NW = num_w(CW);
    localparam int MW = prod_w(CW);

    logic        en;
    logic [3:0]  v_reg;

    logic signed [CW-1:0] cin   [N_COORD];
    logic signed [CW-1:0] c_reg [N_COORD];

    logic signed [PW-1:0] pd1_reg [N_PAIR];
    logic signed [PW-1:0] pd2_reg [N_PAIR];
    logic signed [PW-1:0] pt1_reg [N_PAIR];
    logic signed [PW-1:0] pt2_reg [N_PAIR];
    logic signed [PW-1:0] pu1_reg [N_PAIR];
    logic signed [PW-1:0] pu2_reg [N_PAIR];
    logic signed [CW-1:0] x1a_reg [N_PAIR];
    logic signed [CW-1:0] y1a_reg [N_PAIR];
    logic signed [DW-1:0] dxa_reg [N_PAIR];
    logic signed [DW-1:0] dya_reg [N_PAIR];

    logic signed [SW-1:0] d_reg   [N_PAIR];
    logic signed [SW-1:0] tn_reg  [N_PAIR];
    logic signed [SW-1:0] un_reg  [N_PAIR];
    logic signed [CW-1:0] x1b_reg [N_PAIR];
    logic signed [CW-1:0] y1b_reg [N_PAIR];
    logic signed [DW-1:0] dxb_reg [N_PAIR];
    logic signed [DW-1:0] dyb_reg [N_PAIR];

    logic [N_PAIR-1:0] hit_reg;
    logic [N_PAIR-1:0] sx_reg;
    logic [N_PAIR-1:0] sy_reg;
    logic [NW-1:0]     d4_reg  [N_PAIR];
    logic [MW-1:0]     mx_reg  [N_PAIR];
    logic [MW-1:0]     my_reg  [N_PAIR];
    logic [CW-1:0]     x1c_reg [N_PAIR];
    logic [CW-1:0]     y1c_reg [N_PAIR];

    assign en         = !v_reg[3] || !q_stat.full;
    assign item_ready = en;
    assign push       = v_reg[3] && !q_stat.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[2:0], item_valid};
        end
    end

    // coordinate narrowing: keep the low COORD_BITS bits with the top one as sign; a wider COORD_BITS zero pads
    genvar k;
    generate
        for (k = 0; k < N_COORD; k++)
        begin : g_cin
            if (COORD_BITS <= IN_W)
            begin : g_narrow
                assign cin[k] = coord[k][COORD_BITS-1:0];
            end
            else
            begin : g_wide
                assign cin[k] = {{(COORD_BITS-IN_W){1'b0}}, coord[k]};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    c_reg[k] <= cin[k];
                end
            end
        end
    endgenerate

    genvar p;
    generate
        for (p = 0; p < N_PAIR; p++)
        begin : g_pair
            localparam int Q = (p + 1) % N_PAIR;

            logic signed [DW-1:0] e12x, e12y, e13x, e13y, e34x, e34y, e21x, e21y;
            logic signed [SW-1:0] dr, dn;
            logic                 neg;
            logic signed [SW-1:0] dsel, tsel, usel;
            logic                 hit_c;
            logic [DW-1:0]        adx, ady;

            always_comb
            begin
                e12x = DW'(c_reg[4*p])   - DW'(c_reg[4*p+2]);
                e12y = DW'(c_reg[4*p+1]) - DW'(c_reg[4*p+3]);
                e13x = DW'(c_reg[4*p])   - DW'(c_reg[4*Q]);
                e13y = DW'(c_reg[4*p+1]) - DW'(c_reg[4*Q+1]);
                e34x = DW'(c_reg[4*Q])   - DW'(c_reg[4*Q+2]);
                e34y = DW'(c_reg[4*Q+1]) - DW'(c_reg[4*Q+3]);
                e21x = DW'(c_reg[4*p+2]) - DW'(c_reg[4*p]);
                e21y = DW'(c_reg[4*p+3]) - DW'(c_reg[4*p+1]);
            end

            // stage 2: cross products
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    pd1_reg[p] <= PW'(e12x) * PW'(e34y);
                    pd2_reg[p] <= PW'(e12y) * PW'(e34x);
                    pt1_reg[p] <= PW'(e13x) * PW'(e34y);
                    pt2_reg[p] <= PW'(e13y) * PW'(e34x);
                    pu1_reg[p] <= PW'(e13x) * PW'(e12y);
                    pu2_reg[p] <= PW'(e13y) * PW'(e12x);
                    x1a_reg[p] <= c_reg[4*p];
                    y1a_reg[p] <= c_reg[4*p+1];
                    dxa_reg[p] <= e21x;
                    dya_reg[p] <= e21y;
                end
            end

            // stage 3: determinants with the denominator made positive
            always_comb
            begin
                dr   = SW'(pd1_reg[p]) - SW'(pd2_reg[p]);
                dn   = SW'(pd2_reg[p]) - SW'(pd1_reg[p]);
                neg  = dr[SW-1];
                dsel = neg ? dn : dr;
                tsel = neg ? SW'(pt2_reg[p]) - SW'(pt1_reg[p])
                           : SW'(pt1_reg[p]) - SW'(pt2_reg[p]);
                usel = neg ? SW'(pu2_reg[p]) - SW'(pu1_reg[p])
                           : SW'(pu1_reg[p]) - SW'(pu2_reg[p]);
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    d_reg[p]   <= dsel;
                    tn_reg[p]  <= tsel;
                    un_reg[p]  <= usel;
                    x1b_reg[p] <= x1a_reg[p];
                    y1b_reg[p] <= y1a_reg[p];
                    dxb_reg[p] <= dxa_reg[p];
                    dyb_reg[p] <= dya_reg[p];
                end
            end

            // stage 4: exact range tests and step dividends
            always_comb
            begin
                hit_c = (d_reg[p] != '0) && !tn_reg[p][SW-1] && (tn_reg[p] <= d_reg[p])
                     && !un_reg[p][SW-1] && (un_reg[p] <= d_reg[p]);
                adx   = dxb_reg[p][DW-1] ? DW'(-dxb_reg[p]) : DW'(dxb_reg[p]);
                ady   = dyb_reg[p][DW-1] ? DW'(-dyb_reg[p]) : DW'(dyb_reg[p]);
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    hit_reg[p] <= hit_c;
                    sx_reg[p]  <= dxb_reg[p][DW-1];
                    sy_reg[p]  <= dyb_reg[p][DW-1];
                    d4_reg[p]  <= d_reg[p][NW-1:0];
                    mx_reg[p]  <= MW'(tn_reg[p][NW-1:0]) * MW'(adx);
                    my_reg[p]  <= MW'(tn_reg[p][NW-1:0]) * MW'(ady);
                    x1c_reg[p] <= x1b_reg[p];
                    y1c_reg[p] <= y1b_reg[p];
                end
            end

            assign hit[p] = hit_reg[p];
            assign sx[p]  = sx_reg[p];
            assign sy[p]  = sy_reg[p];
            assign x1[p]  = x1c_reg[p];
            assign y1[p]  = y1c_reg[p];
            assign d[p]   = d4_reg[p];
            assign mx[p]  = mx_reg[p];
            assign my[p]  = my_reg[p];
        end
    endgenerate

endmodule

/* rtl/sta_queue.sv */
// Short item queue between the front and back pipelines.
module sta_queue #(
    parameter int W = 8,
    parameter int D = sta_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [W-1:0]     wdata,
    input  logic             pop,
    output logic [W-1:0]     rdata,
    output sta_pkg::q_stat_t stat
);
    import sta_pkg::*;

    localparam int AW = (D > 1) ? $clog2(D) : 1;
    localparam int CNW = $clog2(D + 1);

    logic [W-1:0]   mem [D];
    logic [AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNW-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(D - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(D - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata      = mem[rd_ptr_reg];
    assign stat.full  = (cnt_reg == CNW'(D));
    assign stat.empty = (cnt_reg == '0);

endmodule

/* rtl/sta_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module sta_div #(
    parameter int COORD_BITS = sta_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sta_pkg::FRAC_BITS_DEF
) (
    input  logic                                             clk,
    input  logic                                             en,
    input  logic [sta_pkg::prod_w(COORD_BITS)-1:0]           m,
    input  logic [sta_pkg::num_w(COORD_BITS)-1:0]            d,
    output logic [sta_pkg::quo_w(COORD_BITS, FRAC_BITS)-1:0] q
);
    import sta_pkg::*;

    localparam int NW = num_w(COORD_BITS);
    localparam int MW = prod_w(COORD_BITS);
    localparam int QW = quo_w(COORD_BITS, FRAC_BITS);
    localparam int XW = MW + FRAC_BITS;

    logic [XW-1:0] n;
    logic [NW-1:0] r_reg  [QW];
    logic [QW-1:0] lo_reg [QW];
    logic [NW-1:0] dv_reg [QW];

    // dividend is m * 2^FRAC_BITS; the top NW bits start below d
    assign n = XW'(m) << FRAC_BITS;

    genvar k;
    generate
        for (k = 0; k < QW; k++)
        begin : g_stage
            logic [NW-1:0] r_in, dv_in;
            logic [QW-1:0] lo_in;
            logic [NW:0]   t, diff;
            logic          ge;

            if (k == 0)
            begin : g_first
                assign r_in  = n[XW-1:QW];
                assign lo_in = n[QW-1:0];
                assign dv_in = d;
            end
            else
            begin : g_next
                assign r_in  = r_reg[k-1];
                assign lo_in = lo_reg[k-1];
                assign dv_in = dv_reg[k-1];
            end

            always_comb
            begin
                t    = {r_in, lo_in[QW-1]};
                diff = t - {1'b0, dv_in};
                ge   = (t >= {1'b0, dv_in});
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[k]  <= ge ? diff[NW-1:0] : t[NW-1:0];
                    lo_reg[k] <= {lo_in[QW-2:0], ge};
                    dv_reg[k] <= dv_in;
                end
            end
        end
    endgenerate

    assign q = lo_reg[QW-1];

endmodule

/* rtl/sta_back.sv */
// Back pipeline: intersection points, cross product and area output.
module sta_back #(
    parameter int COORD_BITS = sta_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sta_pkg::FRAC_BITS_DEF
) (
    input  logic                                                      clk,
    input  logic                                                      rst_n,
    input  sta_pkg::q_stat_t                                          q_stat,
    output logic                                                      pop,
    input  logic [sta_pkg::N_PAIR-1:0]                                hit,
    input  logic [sta_pkg::N_PAIR-1:0]                                sx,
    input  logic [sta_pkg::N_PAIR-1:0]                                sy,
    input  logic [sta_pkg::N_PAIR-1:0][COORD_BITS-1:0]                x1,
    input  logic [sta_pkg::N_PAIR-1:0][COORD_BITS-1:0]                y1,
    input  logic [sta_pkg::N_PAIR-1:0][sta_pkg::num_w(COORD_BITS)-1:0]  d,
    input  logic [sta_pkg::N_PAIR-1:0][sta_pkg::prod_w(COORD_BITS)-1:0] mx,
    input  logic [sta_pkg::N_PAIR-1:0][sta_pkg::prod_w(COORD_BITS)-1:0] my,
    output logic                                                      result_valid,
    input  logic                                                      result_ready,
    output logic                                                      forms_triangle,
    output logic [sta_pkg::AREA_W-1:0]                                area_q16
);
    import sta_pkg::*;

    localparam int CW  = COORD_BITS;
    localparam int NW  = num_w(CW);
    localparam int MW  = prod_w(CW);
    localparam int QW  = quo_w(CW, FRAC_BITS);
    localparam int PXW = CW + FRAC_BITS + 2;
    localparam int XW  = PXW + 1;
    localparam int H   = XW / 2;
    localparam int PLW = XW + H + 1;
    localparam int PHW = 2 * XW - H;
    localparam int PRW = 2 * XW;
    localparam int CRW = PRW + 1;
    localparam int L   = QW + 7;

    typedef struct packed {
        logic [N_PAIR-1:0]          hit;
        logic [N_PAIR-1:0]          sx;
        logic [N_PAIR-1:0]          sy;
        logic [N_PAIR-1:0][CW-1:0]  x1;
        logic [N_PAIR-1:0][CW-1:0]  y1;
    } side_t;

    logic          en;
    logic [L-1:0]  vld_reg;
    side_t         side_reg [QW+1];
    logic [NW-1:0] d_reg  [N_PAIR];
    logic [MW-1:0] mx_reg [N_PAIR];
    logic [MW-1:0] my_reg [N_PAIR];
    logic [QW-1:0] qx [N_PAIR];
    logic [QW-1:0] qy [N_PAIR];

    logic signed [PXW-1:0] px_reg [N_PAIR];
    logic signed [PXW-1:0] py_reg [N_PAIR];
    logic                  hit_p_reg;

    logic signed [XW-1:0]  a_reg, b_reg, c_reg, e_reg;
    logic                  forms_e_reg;

    logic signed [PLW-1:0] pl1_reg, pl2_reg;
    logic signed [PHW-1:0] ph1_reg, ph2_reg;
    logic                  forms_m1_reg;

    logic signed [PRW-1:0] p1_reg, p2_reg;
    logic                  forms_m2_reg;

    logic signed [CRW-1:0] cr_reg;
    logic                  forms_c_reg;

    logic                  forms_a_reg;
    logic [AREA_W-1:0]     area_reg;

    logic [CRW-1:0]        mg;
    logic                  alleq;

    assign en  = !vld_reg[L-1] || result_ready;
    assign pop = en && !q_stat.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[L-2:0], !q_stat.empty};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0].hit <= hit;
            side_reg[0].sx  <= sx;
            side_reg[0].sy  <= sy;
            side_reg[0].x1  <= x1;
            side_reg[0].y1  <= y1;
        end
    end

    genvar k;
    generate
        for (k = 1; k <= QW; k++)
        begin : g_side
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    side_reg[k] <= side_reg[k-1];
                end
            end
        end

        for (k = 0; k < N_PAIR; k++)
        begin : g_pair
            logic signed [PXW-1:0] xb, yb, sxq, syq;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    d_reg[k]  <= d[k];
                    mx_reg[k] <= mx[k];
                    my_reg[k] <= my[k];
                end
            end

            sta_div #(
                .COORD_BITS (COORD_BITS),
                .FRAC_BITS  (FRAC_BITS)
            ) u_div_x (
                .clk (clk),
                .en  (en),
                .m   (mx_reg[k]),
                .d   (d_reg[k]),
                .q   (qx[k])
            );

            sta_div #(
                .COORD_BITS (COORD_BITS),
                .FRAC_BITS  (FRAC_BITS)
            ) u_div_y (
                .clk (clk),
                .en  (en),
                .m   (my_reg[k]),
                .d   (d_reg[k]),
                .q   (qy[k])
            );

            // point = first endpoint in Q form plus the signed step
            always_comb
            begin
                xb  = PXW'($signed(side_reg[QW].x1[k])) <<< FRAC_BITS;
                yb  = PXW'($signed(side_reg[QW].y1[k])) <<< FRAC_BITS;
                sxq = side_reg[QW].sx[k] ? -$signed(PXW'(qx[k])) : $signed(PXW'(qx[k]));
                syq = side_reg[QW].sy[k] ? -$signed(PXW'(qy[k])) : $signed(PXW'(qy[k]));
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    px_reg[k] <= xb + sxq;
                    py_reg[k] <= yb + syq;
                end
            end
        end
    endgenerate

    always_comb
    begin
        alleq = (px_reg[0] == px_reg[1]) && (px_reg[1] == px_reg[2])
             && (py_reg[0] == py_reg[1]) && (py_reg[1] == py_reg[2]);
        mg    = cr_reg[CRW-1] ? CRW'(-cr_reg) : CRW'(cr_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_p_reg    <= &side_reg[QW].hit;

            a_reg        <= XW'(px_reg[0]) - XW'(px_reg[2]);
            b_reg        <= XW'(py_reg[1]) - XW'(py_reg[0]);
            c_reg        <= XW'(px_reg[0]) - XW'(px_reg[1]);
            e_reg        <= XW'(py_reg[2]) - XW'(py_reg[0]);
            forms_e_reg  <= hit_p_reg && !alleq;

            // split multiplies: low half unsigned, high half signed
            pl1_reg      <= PLW'(a_reg) * PLW'($signed({1'b0, b_reg[H-1:0]}));
            ph1_reg      <= PHW'(a_reg) * PHW'($signed(b_reg[XW-1:H]));
            pl2_reg      <= PLW'(c_reg) * PLW'($signed({1'b0, e_reg[H-1:0]}));
            ph2_reg      <= PHW'(c_reg) * PHW'($signed(e_reg[XW-1:H]));
            forms_m1_reg <= forms_e_reg;

            p1_reg       <= (PRW'(ph1_reg) <<< H) + PRW'(pl1_reg);
            p2_reg       <= (PRW'(ph2_reg) <<< H) + PRW'(pl2_reg);
            forms_m2_reg <= forms_m1_reg;

            cr_reg       <= CRW'(p1_reg) - CRW'(p2_reg);
            forms_c_reg  <= forms_m2_reg;

            forms_a_reg  <= forms_c_reg;
            area_reg     <= forms_c_reg ? AREA_W'(mg >> (FRAC_BITS + 1)) : '0;
        end
    end

    assign result_valid   = vld_reg[L-1];
    assign forms_triangle = forms_a_reg;
    assign area_q16       = area_reg;

endmodule

/* rtl/segment_triangle_area_core.sv */
// Top level of the segment triangle area core: front, queue and back pipelines.
//
//  channel   signals                            carries
//  -------   --------------------------------   -----------------------------------
//  item      item_valid / item_ready            twelve coordinates s1_ax .. s3_by
//  result    result_valid / result_ready        forms_triangle, area_q16
//
// One item per cycle sustained while results are taken. Items pass through the
// front pipeline, then the queue, then the back pipeline, whose length is set
// by the bit-per-stage step dividers.
// rst_n clears all valid flags and queue pointers; data registers are not reset.
// A held result stalls only the back; the front keeps taking items until the
// four-entry queue fills.
module segment_triangle_area_core #(
    parameter int COORD_BITS = sta_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sta_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic signed [sta_pkg::IN_W-1:0]    s1_ax,
    input  logic signed [sta_pkg::IN_W-1:0]    s1_ay,
    input  logic signed [sta_pkg::IN_W-1:0]    s1_bx,
    input  logic signed [sta_pkg::IN_W-1:0]    s1_by,
    input  logic signed [sta_pkg::IN_W-1:0]    s2_ax,
    input  logic signed [sta_pkg::IN_W-1:0]    s2_ay,
    input  logic signed [sta_pkg::IN_W-1:0]    s2_bx,
    input  logic signed [sta_pkg::IN_W-1:0]    s2_by,
    input  logic signed [sta_pkg::IN_W-1:0]    s3_ax,
    input  logic signed [sta_pkg::IN_W-1:0]    s3_ay,
    input  logic signed [sta_pkg::IN_W-1:0]    s3_bx,
    input  logic signed [sta_pkg::IN_W-1:0]    s3_by,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic                               forms_triangle,
    output logic [sta_pkg::AREA_W-1:0]         area_q16
);
    import sta_pkg::*;

    localparam int CW  = COORD_BITS;
    localparam int NW  = num_w(CW);
    localparam int MW  = prod_w(CW);
    localparam int QDW = N_PAIR * (3 + 2 * CW + NW + 2 * MW);

    logic [N_COORD-1:0][IN_W-1:0] coord;

    // front side of the queue
    logic                         push;
    logic [N_PAIR-1:0]            f_hit, f_sx, f_sy;
    logic [N_PAIR-1:0][CW-1:0]    f_x1, f_y1;
    logic [N_PAIR-1:0][NW-1:0]    f_d;
    logic [N_PAIR-1:0][MW-1:0]    f_mx, f_my;

    // back side of the queue
    logic                         pop;
    logic [N_PAIR-1:0]            b_hit, b_sx, b_sy;
    logic [N_PAIR-1:0][CW-1:0]    b_x1, b_y1;
    logic [N_PAIR-1:0][NW-1:0]    b_d;
    logic [N_PAIR-1:0][MW-1:0]    b_mx, b_my;

    logic [QDW-1:0]               q_wdata, q_rdata;
    q_stat_t                      q_stat;

    assign coord = {s3_by, s3_bx, s3_ay, s3_ax,
                    s2_by, s2_bx, s2_ay, s2_ax,
                    s1_by, s1_bx, s1_ay, s1_ax};

    sta_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .coord      (coord),
        .q_stat     (q_stat),
        .push       (push),
        .hit        (f_hit),
        .sx         (f_sx),
        .sy         (f_sy),
        .x1         (f_x1),
        .y1         (f_y1),
        .d          (f_d),
        .mx         (f_mx),
        .my         (f_my)
    );

    assign q_wdata = {f_hit, f_sx, f_sy, f_x1, f_y1, f_d, f_mx, f_my};

    sta_queue #(
        .W (QDW),
        .D (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (q_wdata),
        .pop   (pop),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    assign {b_hit, b_sx, b_sy, b_x1, b_y1, b_d, b_mx, b_my} = q_rdata;

    sta_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_stat         (q_stat),
        .pop            (pop),
        .hit            (b_hit),
        .sx             (b_sx),
        .sy             (b_sy),
        .x1             (b_x1),
        .y1             (b_y1),
        .d              (b_d),
        .mx             (b_mx),
        .my             (b_my),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .forms_triangle (forms_triangle),
        .area_q16       (area_q16)
    );

endmodule

/* tb/sv/segment_triangle_area_core_test.sv */
// Testbench for the segment triangle area core: predicted areas checked item by item.
module segment_triangle_area_core_test;
    import sta_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int LATENCY = 4 + 1 + CB + FB + 8;

    typedef logic signed [IN_W-1:0] coord_t;
    typedef struct packed {
        logic              tri_ok;
        logic [AREA_W-1:0] area;
    } area_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    coord_t crd [N_COORD];
    logic result_valid;
    logic result_ready = 1'b0;
    logic forms_triangle;
    logic [AREA_W-1:0] area_q16;

    area_res_t area_queue[$];
    int fail_count = 0;
    int hold_off = 0;      // cycles of forced receiver stall still to go
    bit stall_enable = 1'b1;

    initial for (int k = 0; k < N_COORD; k++) crd[k] = '0;

    always #6 clk = ~clk;

    segment_triangle_area_core DUT (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready),
        .s1_ax(crd[0]), .s1_ay(crd[1]), .s1_bx(crd[2]), .s1_by(crd[3]),
        .s2_ax(crd[4]), .s2_ay(crd[5]), .s2_bx(crd[6]), .s2_by(crd[7]),
        .s3_ax(crd[8]), .s3_ay(crd[9]), .s3_bx(crd[10]), .s3_by(crd[11]),
        .result_valid(result_valid), .result_ready(result_ready),
        .forms_triangle(forms_triangle), .area_q16(area_q16)
    );

    // Sign extend from bit CB-1, as the core sees a coordinate.
    function automatic longint coord_val(coord_t c);
        longint v;
        v = longint'(c) & ((64'sd1 <<< CB) - 1);
        if (v[CB-1]) v = v - (64'sd1 <<< CB);
        return v;
    endfunction

    // Exact t/u range test; point in Q.FB with the step truncated toward zero.
    function automatic bit seg_meet(longint x1, y1, x2, y2, x3, y3, x4, y4,
                                    output longint qx, output longint qy);
        longint d, tn, un;
        logic [127:0] mx, my;
        d  = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
        tn = (x1 - x3) * (y3 - y4) - (y1 - y3) * (x3 - x4);
        un = (x1 - x3) * (y1 - y2) - (y1 - y3) * (x1 - x2);
        qx = 0;
        qy = 0;
        if (d == 0) return 1'b0;
        if (d < 0)
        begin
            d = -d; tn = -tn; un = -un;
        end
        if (tn < 0 || tn > d || un < 0 || un > d) return 1'b0;
        mx = (128'(tn) * 128'(x2 < x1 ? x1 - x2 : x2 - x1) << FB) / 128'(d);
        my = (128'(tn) * 128'(y2 < y1 ? y1 - y2 : y2 - y1) << FB) / 128'(d);
        qx = (x1 <<< FB) + (x2 < x1 ? -longint'(mx) : longint'(mx));
        qy = (y1 <<< FB) + (y2 < y1 ? -longint'(my) : longint'(my));
        return 1'b1;
    endfunction

    function automatic area_res_t triangle_area(coord_t c [N_COORD]);
        longint v [N_COORD];
        longint px [3], py [3];
        bit hit;
        logic signed [127:0] cr;
        area_res_t r;
        for (int k = 0; k < N_COORD; k++) v[k] = coord_val(c[k]);
        hit = 1'b1;
        for (int i = 0; i < N_PAIR; i++)
        begin
            int j;
            j = (i + 1) % 3;
            if (!seg_meet(v[4*i], v[4*i+1], v[4*i+2], v[4*i+3],
                          v[4*j], v[4*j+1], v[4*j+2], v[4*j+3], px[i], py[i]))
                hit = 1'b0;
        end
        r = '0;
        if (!hit) return r;
        if (px[0] == px[1] && px[1] == px[2] && py[0] == py[1] && py[1] == py[2])
            return r;
        cr = 128'(px[0] - px[2]) * 128'(py[1] - py[0])
           - 128'(px[0] - px[1]) * 128'(py[2] - py[0]);
        if (cr < 0) cr = -cr;
        r.tri_ok = 1'b1;
        r.area = AREA_W'(cr >> (FB + 1));
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Mostly short gaps, occasionally long ones.
    function automatic int gap_len();
        if ($urandom_range(9) < 6) return 0;
        if ($urandom_range(9) < 8) return $urandom_range(3);
        return $urandom_range(30);
    endfunction

    // Starts and ends at a falling edge; valid stays up between back-to-back items.
    task automatic send_item(coord_t c [N_COORD]);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            item_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        crd = c;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        area_queue.push_back(triangle_area(c));
        @(negedge clk);
    endtask

    // Receiver ready: random stalls, plus a forced hold-off when requested.
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            result_ready <= 1'b0;
        end
        else if (stall_enable)
            result_ready <= ($urandom_range(9) < 7);
        else
            result_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (area_queue.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                area_res_t w;
                w = area_queue.pop_front();
                if (forms_triangle !== w.tri_ok)
                    report_mismatch("forms_triangle", forms_triangle, w.tri_ok);
                if (area_q16 !== w.area)
                    report_mismatch("area_q16", area_q16, w.area);
            end
        end
    end

    function automatic coord_t rnd_coord();
        case ($urandom_range(4))
            0: return coord_t'($urandom_range(65535));
            1: return coord_t'($urandom_range(1) ? 16'h7fff : 16'h8000);
            default: return coord_t'($signed($urandom_range(64)) - 32);
        endcase
    endfunction

    // Three segments forming a triangle around random corners (extended past them).
    task automatic make_triangle(output coord_t c [N_COORD], input int span);
        int ax, ay, bx, by, cx, cy;
        ax = $signed($urandom_range(2*span)) - span;
        ay = $signed($urandom_range(2*span)) - span;
        bx = $signed($urandom_range(2*span)) - span;
        by = $signed($urandom_range(2*span)) - span;
        cx = $signed($urandom_range(2*span)) - span;
        cy = $signed($urandom_range(2*span)) - span;
        // segments stretched to 2x beyond each corner so the pairs meet
        c[0] = coord_t'(2*ax - bx); c[1] = coord_t'(2*ay - by);
        c[2] = coord_t'(2*bx - ax); c[3] = coord_t'(2*by - ay);
        c[4] = coord_t'(2*bx - cx); c[5] = coord_t'(2*by - cy);
        c[6] = coord_t'(2*cx - bx); c[7] = coord_t'(2*cy - by);
        c[8] = coord_t'(2*cx - ax); c[9] = coord_t'(2*cy - ay);
        c[10] = coord_t'(2*ax - cx); c[11] = coord_t'(2*ay - cy);
    endtask

    task automatic send_list(int v [N_COORD]);
        coord_t c [N_COORD];
        for (int k = 0; k < N_COORD; k++) c[k] = coord_t'(v[k]);
        send_item(c);
    endtask

    // Called at a falling edge; drops valid, waits for all results, ends at a falling edge.
    task automatic wait_drain();
        item_valid <= 1'b0;
        while (area_queue.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_directed();
        coord_t c [N_COORD];
        // plain triangle
        send_list('{0, 0, 10, 0, 10, -1, 5, 9, 6, 9, -1, -1});
        // parallel pair
        send_list('{0, 0, 10, 0, 0, 5, 10, 5, 0, -3, 10, 9});
        // pair that misses
        send_list('{0, 0, 1, 0, 5, -5, 5, 5, 0, 0, 9, 9});
        // all three through one point
        send_list('{-5, 0, 5, 0, 0, -5, 0, 5, -5, -5, 5, 5});
        // touching at endpoints, t = 1 and u = 0
        send_list('{0, 0, 8, 0, 8, 0, 0, 6, 0, 6, 0, 0});
        // fractional intersection points
        send_list('{0, 0, 7, 3, 7, 0, 1, 5, 1, 4, 0, -3});
        // extreme coordinates
        send_list('{-32768, -32768, 32767, -32768, 32767, -32768, -32768, 32767,
                    -32768, 32767, -32768, -32768});
        send_list('{32767, 32767, -32768, 32767, -32768, 32767, 32767, -32768,
                    32767, -32768, 32767, 32767});
        send_list('{-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767,
                    0, -32768, 0, 32767});
        for (int k = 0; k < N_COORD; k++) c[k] = coord_t'(16'hffff);
        send_item(c);
        for (int k = 0; k < N_COORD; k++) c[k] = coord_t'(16'h5555 << (k % 2));
        send_item(c);
        make_triangle(c, 16000);
        send_item(c);
        wait_drain();
    endtask

    task automatic test_random(int count);
        coord_t c [N_COORD];
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(9) < 7)
                make_triangle(c, $urandom_range(1) ? 40 : 16000);
            else
                for (int k = 0; k < N_COORD; k++) c[k] = rnd_coord();
            send_item(c);
        end
    endtask

    // Receiver held off long enough that the queue fills and input stalls.
    task automatic test_backpressure();
        coord_t c [N_COORD];
        wait_drain();
        @(negedge clk);
        hold_off = 3 * LATENCY;
        for (int n = 0; n < 60; n++)
        begin
            make_triangle(c, 100);
            crd = c;
            item_valid <= 1'b1;
            @(posedge clk);
            while (!item_ready) @(posedge clk);
            area_queue.push_back(triangle_area(c));
            @(negedge clk);
        end
        wait_drain();
    endtask

    task automatic test_full_rate();
        coord_t c [N_COORD];
        stall_enable = 1'b0;
        for (int n = 0; n < 100; n++)
        begin
            make_triangle(c, 3000);
            crd = c;
            item_valid <= 1'b1;
            @(posedge clk);
            while (!item_ready) @(posedge clk);
            area_queue.push_back(triangle_area(c));
            @(negedge clk);
        end
        stall_enable = 1'b1;
        wait_drain();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(450);
        test_backpressure();
        test_full_rate();
        test_random(450);
        wait_drain();
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
